// File: sv/fdef_pkg.sv
// Shared types, constants and a helper function for the FAT12 directory entry filter.
package fdef_pkg;

   localparam int unsigned EntryBytes = 32;
   localparam int unsigned PosWidth   = $clog2(EntryBytes);
   localparam int unsigned NameLen    = 11;
   localparam int unsigned NameIdxW   = $clog2(NameLen);

   // Byte offsets inside one entry
   localparam logic [PosWidth-1:0] PosNameFirst = PosWidth'(0);
   localparam logic [PosWidth-1:0] PosAttr      = PosWidth'(11);
   localparam logic [PosWidth-1:0] PosClusterLo = PosWidth'(26);
   localparam logic [PosWidth-1:0] PosClusterHi = PosWidth'(27);
   localparam logic [PosWidth-1:0] PosSize0     = PosWidth'(28);
   localparam logic [PosWidth-1:0] PosSize1     = PosWidth'(29);
   localparam logic [PosWidth-1:0] PosSize2     = PosWidth'(30);
   localparam logic [PosWidth-1:0] PosLast      = PosWidth'(EntryBytes - 1);

   // Attribute codes
   localparam logic [7:0] AttrDir        = 8'h10;
   localparam logic [7:0] AttrFile       = 8'h20;
   localparam logic [7:0] AttrHiddenFile = 8'h27;

   localparam logic RootModeReset = 1'b1;

   // Name bytes, byte 0 at index 0
   typedef logic [NameLen-1:0][7:0] name_type;

   localparam name_type DotName    = {{10{8'h20}}, 8'h2E};
   localparam name_type DotDotName = {{9{8'h20}}, 8'h2E, 8'h2E};

   typedef struct packed {
      logic accepted;
      logic descend;
   } verdict_type;

   function automatic logic char_ok(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A) ||
             c == 8'h20 || c == 8'h5F;
   endfunction

endpackage

// File: sv/fdef_if.sv
// Stream interfaces for directory bytes in and entry records out.
interface fdef_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] entry_byte;

   modport source (output valid, output entry_byte, input ready);
   modport sink   (input valid, input entry_byte, output ready);
endinterface

interface fdef_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        descend;
   logic [7:0]  attribute;
   logic [15:0] first_cluster;
   logic [31:0] file_size;
   logic [63:0] name_base;
   logic [23:0] name_ext;

   modport source (output valid, output accepted, output descend, output attribute,
                   output first_cluster, output file_size, output name_base,
                   output name_ext, input ready);
   modport sink   (input valid, input accepted, input descend, input attribute,
                   input first_cluster, input file_size, input name_base,
                   input name_ext, output ready);
endinterface

// File: sv/fdef_verdict.sv
// Accept / descend decision for one completed directory entry.
module fdef_verdict
   import fdef_pkg::*;
(
   input  name_type    name,
   input  logic [7:0]  attribute,
   input  logic [15:0] first_cluster,
   input  logic        bad_char,
   input  logic        root_mode,
   output verdict_type verdict
);

   logic dot;
   logic sub_dot;
   logic is_dir;
   logic is_file;
   logic attr_ok;
   logic name_ok;

   always_comb begin
      dot     = (name == DotName) || (name == DotDotName);
      sub_dot = !root_mode && dot;
      is_dir  = attribute == AttrDir;
      is_file = (attribute == AttrFile) || (attribute == AttrHiddenFile);
      // cluster >= 2
      attr_ok = (is_dir && ((first_cluster[15:1] != 15'd0) || sub_dot)) || is_file;
      name_ok = !bad_char || sub_dot;
      verdict.accepted = attr_ok && name_ok;
      verdict.descend  = attr_ok && name_ok && is_dir && !dot;
   end

endmodule

// File: sv/fat12_dir_entry_filter_core.sv
// Top level: FAT12 directory byte stream to per-entry records with accept verdict.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+---------------------------------------------
//   req_bus | in  | valid/ready      | entry_byte[7:0]
//   rsp_bus | out | valid/ready      | accepted, descend, attribute, first_cluster,
//           |     |                  | file_size, name_base, name_ext
//   csr     | in  | csr_wr_en only   | csr_wr_data = root_mode
//
// One byte per cycle sustained. An entry's record is registered at the edge that takes
// its last byte (offset 31) and is offered on rsp_bus from the next cycle; bytes at other
// offsets are taken even while a record waits on rsp_bus. Only the last byte of an entry
// stalls, and only while the previous record is still held with rsp_bus.ready low.
// Synchronous reset restarts at offset 0 and sets root rules; no clearing pass is needed.
module fat12_dir_entry_filter_core
   import fdef_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   fdef_req_if.sink          req_bus,
   fdef_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   // control state
   logic [PosWidth-1:0] pos_ff;
   logic                bad_ff;
   logic                rsp_valid_ff;
   logic                root_mode_ff;

   // entry holds
   name_type            name_ff;
   logic [7:0]          attr_ff;
   logic [15:0]         cluster_ff;
   logic [23:0]         size_low_ff;

   // result register
   logic                acc_ff;
   logic                desc_ff;
   logic [7:0]          out_attr_ff;
   logic [15:0]         out_cluster_ff;
   logic [31:0]         out_size_ff;
   name_type            out_name_ff;

   logic                last_byte;
   logic                take;
   logic                byte_bad;
   logic                bad_in;
   verdict_type         verdict;

   assign last_byte = pos_ff == PosLast;
   // a record slot is only needed for the last byte of an entry
   assign req_bus.ready = !last_byte || !rsp_valid_ff || rsp_bus.ready;
   assign take = req_bus.valid && req_bus.ready;
   assign byte_bad = !char_ok(req_bus.entry_byte);

   always_comb begin
      if (pos_ff == PosNameFirst) begin
         bad_in = byte_bad;
      end else if (pos_ff < PosAttr) begin
         bad_in = bad_ff || byte_bad;
      end else begin
         bad_in = bad_ff;
      end
   end

   fdef_verdict u_verdict (
      .name          (name_ff),
      .attribute     (attr_ff),
      .first_cluster (cluster_ff),
      .bad_char      (bad_ff),
      .root_mode     (root_mode_ff),
      .verdict       (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         root_mode_ff <= RootModeReset;
      end else begin
         if (csr_wr_en) begin
            root_mode_ff <= csr_wr_data;
         end
         // a new record may replace one that leaves in the same cycle
         if (take && last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            pos_ff <= pos_ff + PosWidth'(1);
            bad_ff <= bad_in;
         end
      end
   end

   // payload holds, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         if (pos_ff < PosAttr) begin
            name_ff[pos_ff[NameIdxW-1:0]] <= req_bus.entry_byte;
         end
         case (pos_ff)
            PosAttr:      attr_ff           <= req_bus.entry_byte;
            PosClusterLo: cluster_ff[7:0]   <= req_bus.entry_byte;
            PosClusterHi: cluster_ff[15:8]  <= req_bus.entry_byte;
            PosSize0:     size_low_ff[7:0]  <= req_bus.entry_byte;
            PosSize1:     size_low_ff[15:8] <= req_bus.entry_byte;
            PosSize2:     size_low_ff[23:16] <= req_bus.entry_byte;
            default: ;
         endcase
         if (last_byte) begin
            acc_ff         <= verdict.accepted;
            desc_ff        <= verdict.descend;
            out_attr_ff    <= attr_ff;
            out_cluster_ff <= cluster_ff;
            out_size_ff    <= {req_bus.entry_byte, size_low_ff};
            out_name_ff    <= name_ff;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.accepted      = acc_ff;
   assign rsp_bus.descend       = desc_ff;
   assign rsp_bus.attribute     = out_attr_ff;
   assign rsp_bus.first_cluster = out_cluster_ff;
   assign rsp_bus.file_size     = out_size_ff;
   // name byte 0 lands in the top bits
   assign rsp_bus.name_base = {out_name_ff[0], out_name_ff[1], out_name_ff[2],
                               out_name_ff[3], out_name_ff[4], out_name_ff[5],
                               out_name_ff[6], out_name_ff[7]};
   assign rsp_bus.name_ext  = {out_name_ff[8], out_name_ff[9], out_name_ff[10]};

endmodule

// File: sv/fdef_checker.sv
// Port-level checker for the directory entry filter, bound to the top level.
module fdef_checker
   import fdef_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic       rsp_descend,
   input logic [7:0] rsp_attribute
);

   // a held transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_descend |-> rsp_accepted && rsp_attribute == AttrDir)
      else $error("descend on an entry that is not an accepted directory");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         rsp_attribute == AttrDir || rsp_attribute == AttrFile ||
         rsp_attribute == AttrHiddenFile)
      else $error("accepted entry with a foreign attribute");

endmodule

bind fat12_dir_entry_filter_core fdef_checker u_fdef_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_accepted  (rsp_bus.accepted),
   .rsp_descend   (rsp_bus.descend),
   .rsp_attribute (rsp_bus.attribute)
);
